@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("same-cycle assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("next-cycle assertion failed");

`endif

@@ rtl/core/bir_pkg.sv @@
package bir_pkg;

  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  localparam logic [1:0] CFG_SRC_ROWS = 2'd0;
  localparam logic [1:0] CFG_SRC_COLS = 2'd1;
  localparam logic [1:0] CFG_DST_ROWS = 2'd2;
  localparam logic [1:0] CFG_DST_COLS = 2'd3;

  localparam int SRC_W   = 9;
  localparam int DST_W   = 13;
  localparam int COORD_W = 12;
  localparam int PIX_W   = 8;

  localparam logic [1:0] COMP_GAP = 2'd3;

  typedef struct packed {
    logic                opcode;
    logic [COORD_W-1:0]  row;
    logic [COORD_W-1:0]  col;
    logic [PIX_W-1:0]    pixel;
  } bir_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic             status;
  } bir_out_t;

  typedef struct packed {
    logic             vld;
    logic             comp;
    logic             oor;
    logic             wr_ok;
    logic [PIX_W-1:0] pix;
  } bir_ctl_t;

endpackage

@@ rtl/core/bilinear_image_resize.sv @@
// A compute request goes through the control delay line and dividers, then the fetch and
// interpolation registers. Busy after a compute request spaces compute requests for the
// four reads of the single-read-port source memory; write requests are taken every cycle
// while busy is low. Results cannot be stalled. Synchronous active-low reset clears the
// control state and sets the configuration to 256; datapath and memory are not cleared.
module bilinear_image_resize import bir_pkg::*; #(
  parameter int MAX_ROWS  = 256,
  parameter int MAX_COLS  = 256,
  parameter int FRAC_BITS = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  bir_in_t          in_req,
  output logic             out_valid,
  output bir_out_t         out_data,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_idx,
  input  logic [DST_W-1:0] cfg_data
);

  localparam int Q   = SRC_W + FRAC_BITS;
  localparam int DLY = Q + 1;
  localparam int AW  = $clog2(MAX_ROWS * MAX_COLS);

  logic [SRC_W-1:0] src_rows_r, src_cols_r;
  logic [DST_W-1:0] dst_rows_r, dst_cols_r;
  logic [SRC_W-1:0] src_r_eff, src_c_eff;
  logic [1:0]       cool_r, cool_nxt;
  logic             accept;
  bir_ctl_t         ctl_in;
  logic [AW-1:0]    waddr_in;
  bir_ctl_t         ctl_r   [DLY];
  logic [AW-1:0]    waddr_r [DLY];
  logic [Q-1:0]     rquo, cquo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_rows_r <= SRC_W'(256);
      src_cols_r <= SRC_W'(256);
      dst_rows_r <= DST_W'(256);
      dst_cols_r <= DST_W'(256);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_SRC_ROWS: src_rows_r <= cfg_data[SRC_W-1:0];
        CFG_SRC_COLS: src_cols_r <= cfg_data[SRC_W-1:0];
        CFG_DST_ROWS: dst_rows_r <= cfg_data;
        default:      dst_cols_r <= cfg_data;
      endcase
    end
  end

  assign src_r_eff = (src_rows_r == '0) ? SRC_W'(1) :
                     ((32'(src_rows_r) > MAX_ROWS) ? SRC_W'(MAX_ROWS) : src_rows_r);
  assign src_c_eff = (src_cols_r == '0) ? SRC_W'(1) :
                     ((32'(src_cols_r) > MAX_COLS) ? SRC_W'(MAX_COLS) : src_cols_r);

  assign busy     = (cool_r != 2'd0);
  assign accept   = start && !busy;
  assign cool_nxt = (accept && (in_req.opcode == OP_COMPUTE)) ? COMP_GAP :
                    (busy ? cool_r - 2'd1 : 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cool_r <= 2'd0;
    end else begin
      cool_r <= cool_nxt;
    end
  end

  always_comb begin
    ctl_in.vld   = accept;
    ctl_in.comp  = (in_req.opcode == OP_COMPUTE);
    ctl_in.oor   = ({1'b0, in_req.row} >= dst_rows_r) || ({1'b0, in_req.col} >= dst_cols_r);
    ctl_in.wr_ok = (32'(in_req.row) < MAX_ROWS) && (32'(in_req.col) < MAX_COLS);
    ctl_in.pix   = in_req.pixel;
  end

  assign waddr_in = AW'(AW'(in_req.row) * AW'(MAX_COLS) + AW'(in_req.col));

  for (genvar k = 0; k < DLY; k++) begin : g_line
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[k] <= '0;
      end else begin
        ctl_r[k] <= (k == 0) ? ctl_in : ctl_r[(k == 0) ? 0 : k-1];
      end
      waddr_r[k] <= (k == 0) ? waddr_in : waddr_r[(k == 0) ? 0 : k-1];
    end
  end

  bir_axis_div #(.FRAC_BITS(FRAC_BITS)) u_div_row (
    .clk  (clk),
    .idx  (in_req.row),
    .size (src_r_eff),
    .dvs  (dst_rows_r),
    .quo  (rquo)
  );

  bir_axis_div #(.FRAC_BITS(FRAC_BITS)) u_div_col (
    .clk  (clk),
    .idx  (in_req.col),
    .size (src_c_eff),
    .dvs  (dst_cols_r),
    .quo  (cquo)
  );

  bir_fetch #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_COLS  (MAX_COLS),
    .FRAC_BITS (FRAC_BITS),
    .AW        (AW)
  ) u_fetch (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl_r[DLY-1]),
    .waddr     (waddr_r[DLY-1]),
    .rquo      (rquo),
    .cquo      (cquo),
    .src_r_eff (src_r_eff),
    .src_c_eff (src_c_eff),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

@@ rtl/core/bir_axis_div.sv @@
module bir_axis_div import bir_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic                        clk,
  input  logic [COORD_W-1:0]          idx,
  input  logic [SRC_W-1:0]            size,
  input  logic [DST_W-1:0]            dvs,
  output logic [SRC_W+FRAC_BITS-1:0]  quo
);

  localparam int Q  = SRC_W + FRAC_BITS;
  localparam int NW = COORD_W + SRC_W;

  logic [NW-1:0]    num_r;
  logic [DST_W-1:0] rem_r [Q];
  logic [Q-1:0]     sh_r  [Q];

  always_ff @(posedge clk) begin
    num_r <= NW'(idx) * NW'(size);
  end

  for (genvar k = 0; k < Q; k++) begin : g_stage
    logic [DST_W-1:0] rem_in;
    logic [Q-1:0]     sh_in;
    logic [DST_W:0]   trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_in = DST_W'(num_r[NW-1:SRC_W]);
      assign sh_in  = {num_r[SRC_W-1:0], {FRAC_BITS{1'b0}}};
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign sh_in  = sh_r[k-1];
    end

    assign trial = {rem_in, sh_in[Q-1]};
    assign ge    = trial >= {1'b0, dvs};

    always_ff @(posedge clk) begin
      rem_r[k] <= ge ? DST_W'(trial - {1'b0, dvs}) : trial[DST_W-1:0];
      sh_r[k]  <= {sh_in[Q-2:0], ge};
    end
  end

  assign quo = sh_r[Q-1];

endmodule

@@ rtl/core/bir_fetch.sv @@
module bir_fetch import bir_pkg::*; #(
  parameter int MAX_ROWS  = 256,
  parameter int MAX_COLS  = 256,
  parameter int FRAC_BITS = 8,
  parameter int AW        = $clog2(MAX_ROWS * MAX_COLS)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bir_ctl_t                    ctl,
  input  logic [AW-1:0]               waddr,
  input  logic [SRC_W+FRAC_BITS-1:0]  rquo,
  input  logic [SRC_W+FRAC_BITS-1:0]  cquo,
  input  logic [SRC_W-1:0]            src_r_eff,
  input  logic [SRC_W-1:0]            src_c_eff,
  output logic                        out_valid,
  output bir_out_t                    out_data
);

  localparam int Q     = SRC_W + FRAC_BITS;
  localparam int DEPTH = MAX_ROWS * MAX_COLS;

  function automatic logic [PIX_W-1:0] lerp(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b,
                                            input logic [FRAC_BITS-1:0] f);
    logic [FRAC_BITS:0]   wa;
    logic [FRAC_BITS+9:0] acc;
    wa  = ((FRAC_BITS+1)'(1) << FRAC_BITS) - {1'b0, f};
    acc = (FRAC_BITS+10)'(a) * (FRAC_BITS+10)'(wa) + (FRAC_BITS+10)'(b) * (FRAC_BITS+10)'(f);
    return acc[FRAC_BITS+7:FRAC_BITS];
  endfunction

  logic [PIX_W-1:0] mem_r [DEPTH];
  logic [PIX_W-1:0] rdata_r;

  logic [SRC_W-1:0]     rf, rc, cf, cc;
  logic [SRC_W:0]       rf1, cf1;
  logic                 arrive, wr;

  logic [SRC_W-1:0]     f_rf_r, f_rc_r, f_cf_r, f_cc_r;
  logic [FRAC_BITS-1:0] f_rfr_r, f_cfr_r;
  logic                 f_oor_r;
  logic                 f_act_r, f_act_nxt;
  logic [1:0]           fcnt_r, fcnt_nxt;
  logic [SRC_W-1:0]     sel_r, sel_c;
  logic [AW-1:0]        raddr;

  logic                 d_vld_r;
  logic [1:0]           d_tag_r;
  logic [PIX_W-1:0]     a_r, q1_r, q2_r;
  logic [FRAC_BITS-1:0] g_rfr_r, g_cfr_r;
  logic                 g_oor_r;
  logic                 fin_r;
  logic                 out_valid_r;
  bir_out_t             out_data_r;

  assign arrive = ctl.vld && ctl.comp;
  assign wr     = ctl.vld && !ctl.comp && ctl.wr_ok;

  assign rf  = rquo[Q-1:FRAC_BITS];
  assign cf  = cquo[Q-1:FRAC_BITS];
  assign rf1 = {1'b0, rf} + 1'b1;
  assign cf1 = {1'b0, cf} + 1'b1;
  assign rc  = ((rf1 < {1'b0, src_r_eff}) && (rquo[FRAC_BITS-1:0] != '0)) ?
               rf1[SRC_W-1:0] : rf;
  assign cc  = ((cf1 < {1'b0, src_c_eff}) && (cquo[FRAC_BITS-1:0] != '0)) ?
               cf1[SRC_W-1:0] : cf;

  assign f_act_nxt = arrive || (f_act_r && (fcnt_r != 2'd3));
  assign fcnt_nxt  = arrive ? 2'd0 : fcnt_r + 2'd1;

  always_comb begin
    unique case (fcnt_r)
      2'd0: begin
        sel_r = f_rf_r;
        sel_c = f_cf_r;
      end
      2'd1: begin
        sel_r = f_rc_r;
        sel_c = f_cf_r;
      end
      2'd2: begin
        sel_r = f_rf_r;
        sel_c = f_cc_r;
      end
      default: begin
        sel_r = f_rc_r;
        sel_c = f_cc_r;
      end
    endcase
  end

  assign raddr = AW'(AW'(sel_r) * AW'(MAX_COLS) + AW'(sel_c));

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[waddr] <= ctl.pix;
    end
    rdata_r <= mem_r[raddr];
  end

  always_ff @(posedge clk) begin
    if (arrive) begin
      f_rf_r  <= rf;
      f_rc_r  <= rc;
      f_cf_r  <= cf;
      f_cc_r  <= cc;
      f_rfr_r <= rquo[FRAC_BITS-1:0];
      f_cfr_r <= cquo[FRAC_BITS-1:0];
      f_oor_r <= ctl.oor;
    end
    d_tag_r <= fcnt_r;
    if (d_vld_r) begin
      unique case (d_tag_r)
        2'd0: begin
          a_r     <= rdata_r;
          g_rfr_r <= f_rfr_r;
          g_cfr_r <= f_cfr_r;
          g_oor_r <= f_oor_r;
        end
        2'd1: q1_r <= lerp(a_r, rdata_r, g_rfr_r);
        2'd2: a_r  <= rdata_r;
        default: q2_r <= lerp(a_r, rdata_r, g_rfr_r);
      endcase
    end
    if (fin_r) begin
      out_data_r.value  <= g_oor_r ? '0 : lerp(q1_r, q2_r, g_cfr_r);
      out_data_r.status <= g_oor_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_act_r     <= 1'b0;
      fcnt_r      <= 2'd0;
      d_vld_r     <= 1'b0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      f_act_r     <= f_act_nxt;
      fcnt_r      <= fcnt_nxt;
      d_vld_r     <= f_act_r;
      fin_r       <= d_vld_r && (d_tag_r == 2'd3);
      out_valid_r <= fin_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ rtl/core/bir_checker.sv @@
`include "assert_macros.svh"

module bir_checker import bir_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input bir_in_t  in_req,
  input logic     out_valid,
  input bir_out_t out_data
);

  `ASSERT_NEXT(a_comp_gap, clk, rst_n, start && !busy && (in_req.opcode == OP_COMPUTE), busy)
  `ASSERT_SAME(a_oor_zero, clk, rst_n, out_valid && out_data.status, out_data.value == '0)
  `ASSERT_NEXT(a_out_spaced, clk, rst_n, out_valid, !out_valid)

endmodule

bind bilinear_image_resize bir_checker u_bir_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_req    (in_req),
  .out_valid (out_valid),
  .out_data  (out_data)
);
